// ===== rtl/fsfc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the field sensor fault classifier: register codes, state codes,
// configuration and front-end result types, and small shared helper functions.
// No dependencies.
package fsfc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int THR_BITS    = 12;
    localparam int PCT_BITS    = 7;
    localparam int CNT_BITS    = 13;
    localparam int RATE_BITS   = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = CNT_BITS + PCT_BITS;

    localparam logic [CNT_BITS-1:0]  CNT_MAX  = '1;
    localparam logic [PCT_BITS-1:0]  PCT_FULL = PCT_BITS'(100);
    localparam logic [THR_BITS-1:0]  PERIOD_RESET = THR_BITS'(1000);

    localparam logic [1:0] FA_NONE = 2'd0;
    localparam logic [1:0] FA_AMP  = 2'd1;
    localparam logic [1:0] FA_RATE = 2'd2;

    localparam logic [2:0] CODE_IDLE    = 3'd0;
    localparam logic [2:0] CODE_OVER    = 3'd1;
    localparam logic [2:0] CODE_IMPULSE = 3'd2;
    localparam logic [2:0] CODE_FAST    = 3'd3;
    localparam logic [2:0] CODE_HOT     = 3'd4;

    typedef enum logic [2:0] {
        REG_IMPULSE_THR = 3'd0,
        REG_FAST_THR    = 3'd1,
        REG_SLOW_THR    = 3'd2,
        REG_AMP_THR     = 3'd3,
        REG_MIN_OBS     = 3'd4,
        REG_UPPER_PCT   = 3'd5,
        REG_LOWER_PCT   = 3'd6,
        REG_PERIOD      = 3'd7
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_OVER    = 5'b00010,
        ST_IMPULSE = 5'b00100,
        ST_FAST    = 5'b01000,
        ST_HOT     = 5'b10000
    } class_state_t;

    typedef struct packed {
        logic [THR_BITS-1:0] impulse_thr;
        logic [THR_BITS-1:0] fast_thr;
        logic [THR_BITS-1:0] slow_thr;
        logic [THR_BITS-1:0] amp_thr;
        logic [THR_BITS-1:0] min_obs;
        logic [PCT_BITS-1:0] upper_pct;
        logic [PCT_BITS-1:0] lower_pct;
        logic [THR_BITS-1:0] period;
    } cfg_t;

    typedef struct packed {
        logic                        pos;
        logic                        neg;
        logic [SAMPLE_BITS-1:0]      mag;
        logic signed [RATE_BITS-1:0] rate;
        logic                        f_imp;
        logic                        f_fast;
        logic                        f_amp;
    } front_t;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_BITS'(1);
    endfunction

    function automatic logic rate_above(input logic signed [RATE_BITS-1:0] rate,
                                        input logic [THR_BITS-1:0] thr);
        logic signed [RATE_BITS:0] r;
        logic signed [RATE_BITS:0] t;
        r = {rate[RATE_BITS-1], rate};
        t = $signed({{(RATE_BITS+1-THR_BITS){1'b0}}, thr});
        return r > t;
    endfunction

    function automatic logic [2:0] state_code(input class_state_t s);
        case (s)
            ST_OVER:    return CODE_OVER;
            ST_IMPULSE: return CODE_IMPULSE;
            ST_FAST:    return CODE_FAST;
            ST_HOT:     return CODE_HOT;
            default:    return CODE_IDLE;
        endcase
    endfunction

endpackage

// ===== rtl/fsfc_front.sv =====
`timescale 1ns / 1ps
// Signal conditioning: offset removal, polarity, magnitude, rate of change and
// the three threshold flags for one sample. Depends on fsfc_pkg.
module fsfc_front import fsfc_pkg::*; #(
    parameter int QUIESCENT_LEVEL = 2048
) (
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   prev_pos,
    input  logic                   prev_neg,
    input  logic [SAMPLE_BITS-1:0] prev_mag,
    input  cfg_t                   cfg,
    output front_t                 res
);

    localparam logic signed [RATE_BITS:0] QLEV = (RATE_BITS+1)'(QUIESCENT_LEVEL);

    logic signed [RATE_BITS:0]   level;
    logic [RATE_BITS:0]          abs_level;
    logic                        crossing;
    logic [SAMPLE_BITS-1:0]      mag;
    logic signed [RATE_BITS-1:0] rate;
    logic                        f_imp;

    always_comb begin
        level     = $signed({2'b00, sample}) - QLEV;
        abs_level = level[RATE_BITS] ? (RATE_BITS+1)'(0) - level : level;
        // The magnitude saturates at the full sample range.
        mag       = (abs_level[RATE_BITS:SAMPLE_BITS] != '0) ? '1
                                                              : abs_level[SAMPLE_BITS-1:0];
        res.pos   = !level[RATE_BITS] && (level != '0);
        res.neg   = level[RATE_BITS];
        crossing  = !((prev_pos && res.pos) || (prev_neg && res.neg));
        rate      = crossing ? $signed({1'b0, mag})
                             : $signed({1'b0, mag}) - $signed({1'b0, prev_mag});
        f_imp     = rate_above(rate, cfg.impulse_thr);
        res.mag    = mag;
        res.rate   = rate;
        res.f_imp  = f_imp;
        res.f_fast = !f_imp && rate_above(rate, cfg.fast_thr);
        res.f_amp  = mag > cfg.amp_thr;
    end

endmodule

// ===== rtl/field_sensor_fault_classifier.sv =====
`timescale 1ns / 1ps
// Top level of the field sensor fault classifier: input and result registers,
// configuration registers and the five-state classifier. Depends on fsfc_pkg
// and fsfc_front.
//
//  Channel  Direction  Beat contents
//  s_       in         tdata[11:0] adc_sample
//  m_       out        tdata[2:0] fsm_state, [5:3] flags, [17:6] magnitude,
//                      [30:18] rate, [32:31] alarm_kind
//  cfg_     in         cfg_index register number, cfg_data value
//
// Without back-pressure on the result, one beat is accepted per cycle and
// passes the input register, the combinational classifier update and the
// result register. When the result is stalled the input register still takes
// one more beat. Reset is synchronous, active low, and returns the valid flags,
// configuration and classifier to their initial values, not the data registers.
module field_sensor_fault_classifier import fsfc_pkg::*; #(
    parameter int QUIESCENT_LEVEL = 2048,
    parameter int NOISE_LEVEL     = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // adc_sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // fsm_state, flags, magnitude, rate, alarm_kind
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [THR_BITS-1:0] cfg_data
);

    localparam logic signed [RATE_BITS:0] NOISE = (RATE_BITS+1)'(NOISE_LEVEL);

    cfg_t                   cfg_reg;
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   out_valid_reg;
    logic [39:0]            out_data_reg;

    logic                   prev_pos_reg;
    logic                   prev_neg_reg;
    logic [SAMPLE_BITS-1:0] prev_mag_reg;
    logic                   prev_rate_neg_reg;
    class_state_t           state_reg;
    class_state_t           state_next;
    logic [CNT_BITS-1:0]    obs_reg;
    logic [CNT_BITS-1:0]    obs_next;
    logic [CNT_BITS-1:0]    pos_reg;
    logic [CNT_BITS-1:0]    pos_next;
    logic [SAMPLE_BITS-1:0] start_reg;
    logic [SAMPLE_BITS-1:0] start_next;
    logic                   amp_seen_reg;
    logic                   amp_seen_next;
    logic [1:0]             fa;

    front_t                 fr;
    logic                   advance;
    logic                   fire;
    logic [CNT_BITS-1:0]    obs_inc;
    logic [CNT_BITS-1:0]    pos_new;
    logic                   pos_up;
    logic [PROD_BITS-1:0]   pos_prod;
    logic [PROD_BITS-1:0]   up_prod;
    logic [PROD_BITS-1:0]   low_prod;
    logic                   above;
    logic                   below;
    logic                   noise_ok;
    logic                   slow_ok;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    fsfc_front #(
        .QUIESCENT_LEVEL(QUIESCENT_LEVEL)
    ) u_front (
        .sample   (in_sample_reg),
        .prev_pos (prev_pos_reg),
        .prev_neg (prev_neg_reg),
        .prev_mag (prev_mag_reg),
        .cfg      (cfg_reg),
        .res      (fr)
    );

    always_comb begin
        obs_inc = sat_inc(obs_reg);
        slow_ok = rate_above(fr.rate, cfg_reg.slow_thr) &&
                  (obs_inc < CNT_BITS'(cfg_reg.period >> 3));
        case (state_reg)
            ST_OVER:    pos_up = fr.f_amp;
            ST_IMPULSE: pos_up = fr.f_amp || fr.f_fast || slow_ok;
            ST_FAST:    pos_up = fr.f_fast || fr.f_amp;
            ST_HOT:     pos_up = fr.f_amp;
            default:    pos_up = 1'b0;
        endcase
        pos_new  = pos_up ? sat_inc(pos_reg) : pos_reg;
        pos_prod = PROD_BITS'(pos_new) * PROD_BITS'(PCT_FULL);
        up_prod  = PROD_BITS'(cfg_reg.upper_pct) * PROD_BITS'(obs_inc);
        low_prod = PROD_BITS'(cfg_reg.lower_pct) * PROD_BITS'(obs_inc);
        above    = pos_prod > up_prod;
        below    = pos_prod < low_prod;
        noise_ok = ($signed({2'b00, fr.mag}) - $signed({2'b00, start_reg})) > NOISE;
    end

    always_comb begin
        state_next    = state_reg;
        obs_next      = obs_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        amp_seen_next = amp_seen_reg;
        fa            = FA_NONE;
        case (state_reg)
            ST_OVER: begin
                obs_next = obs_inc;
                pos_next = pos_new;
                if (obs_inc > CNT_BITS'(cfg_reg.min_obs)) begin
                    if (above) begin
                        state_next = ST_HOT;
                        pos_next   = '0;
                    end else if (below) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IMPULSE, ST_FAST: begin
                obs_next = obs_inc;
                pos_next = pos_new;
                if (state_reg == ST_IMPULSE) begin
                    if (fr.f_amp) begin
                        state_next = ST_OVER;
                    end else if (fr.f_fast) begin
                        state_next = ST_FAST;
                    end
                end else if (!fr.f_fast && fr.f_amp) begin
                    state_next = ST_OVER;
                end
                if (obs_inc >= CNT_BITS'(cfg_reg.min_obs)) begin
                    if (above) begin
                        if (noise_ok) begin
                            state_next = ST_HOT;
                            pos_next   = '0;
                        end
                    end else if (below) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HOT: begin
                obs_next = obs_inc;
                pos_next = pos_new;
                if (fr.f_amp) begin
                    amp_seen_next = 1'b1;
                end
                if (obs_inc > CNT_BITS'(cfg_reg.period)) begin
                    if (pos_new == '0) begin
                        state_next = ST_IDLE;
                        fa         = amp_seen_next ? FA_AMP : FA_RATE;
                    end
                    obs_next = '0;
                    pos_next = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
                if (fr.f_imp || fr.f_fast || fr.f_amp) begin
                    obs_next   = CNT_BITS'(1);
                    pos_next   = CNT_BITS'(1);
                    start_next = fr.mag;
                    if (fr.f_amp) begin
                        state_next = ST_OVER;
                    end else if (fr.f_imp) begin
                        state_next = ST_IMPULSE;
                    end else if (fr.f_fast && !prev_rate_neg_reg) begin
                        state_next = ST_FAST;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{impulse_thr: '0, fast_thr: '0, slow_thr: '0, amp_thr: '0,
                         min_obs: '0, upper_pct: '0, lower_pct: '0,
                         period: PERIOD_RESET};
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_IMPULSE_THR: cfg_reg.impulse_thr <= cfg_data;
                REG_FAST_THR:    cfg_reg.fast_thr    <= cfg_data;
                REG_SLOW_THR:    cfg_reg.slow_thr    <= cfg_data;
                REG_AMP_THR:     cfg_reg.amp_thr     <= cfg_data;
                REG_MIN_OBS:     cfg_reg.min_obs     <= cfg_data;
                REG_UPPER_PCT:   cfg_reg.upper_pct   <= cfg_data[PCT_BITS-1:0];
                REG_LOWER_PCT:   cfg_reg.lower_pct   <= cfg_data[PCT_BITS-1:0];
                REG_PERIOD:      cfg_reg.period      <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            prev_pos_reg      <= 1'b0;
            prev_neg_reg      <= 1'b0;
            prev_mag_reg      <= '0;
            prev_rate_neg_reg <= 1'b0;
            state_reg         <= ST_IDLE;
            obs_reg           <= '0;
            pos_reg           <= '0;
            start_reg         <= '0;
            amp_seen_reg      <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                prev_pos_reg      <= fr.pos;
                prev_neg_reg      <= fr.neg;
                prev_mag_reg      <= fr.mag;
                prev_rate_neg_reg <= fr.rate[RATE_BITS-1];
                state_reg         <= state_next;
                obs_reg           <= obs_next;
                pos_reg           <= pos_next;
                start_reg         <= start_next;
                amp_seen_reg      <= amp_seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (fire) begin
            out_data_reg <= {7'd0, fa, fr.rate, fr.mag,
                             fr.f_amp, fr.f_fast, fr.f_imp, state_code(state_next)};
        end
    end

endmodule

// ===== rtl/fsfc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the field sensor fault classifier and the bind that
// attaches it to the top level. Depends on field_sensor_fault_classifier.
module fsfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    localparam logic [2:0] IDLE_CODE = 3'd0;
    localparam logic [1:0] NO_ALARM  = 2'd0;

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid after reset.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result beat changed.");

    a_alarm_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[32:31] != NO_ALARM) |-> m_tdata[2:0] == IDLE_CODE)
        else $error("False alarm reported outside the idle state.");

    a_rate_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
        else $error("Impulse and fast rise flagged together.");

endmodule

bind field_sensor_fault_classifier fsfc_checker u_fsfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/field_sensor_fault_classifier_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for field_sensor_fault_classifier: directed sequences and
// random sample bursts against a built-in classifier prediction, with stalls on both
// sides. Depends on fsfc_pkg and the block's RTL.
module field_sensor_fault_classifier_tb;
    import fsfc_pkg::*;

    localparam int QUIESCENT    = 2048;
    localparam int NOISE_MARGIN = 16;
    localparam int RANDOM_ITEMS = 820;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [2:0]  fsm_state;
        logic [2:0]  flags;
        logic [11:0] magnitude;
        logic [12:0] rate;
        logic [1:0]  alarm_kind;
    } verdict_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;

    field_sensor_fault_classifier DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    logic [11:0] pending_samples[$];
    verdict_t    expected_verdicts[$];
    int unsigned pushed_count, accepted_count, checked_count, mismatches;
    int unsigned cycle_count, input_stalls, reg_writes, amp_alarms, rate_alarms;
    logic [4:0]  states_seen = '0;
    bit          sample_taken;

    // Shadow of the configuration and classifier state.
    cfg_t        shadow;
    int          last_pol, last_mag, last_rate, anchor_mag, obs_cnt, pos_cnt;
    logic [2:0]  cls;
    bit          amp_hot_seen;

    function automatic int bump(input int v);
        return (v < int'(CNT_MAX)) ? v + 1 : int'(CNT_MAX);
    endfunction

    function automatic bit share_above();
        return 100 * pos_cnt > int'(shadow.upper_pct) * obs_cnt;
    endfunction

    function automatic bit share_below();
        return 100 * pos_cnt < int'(shadow.lower_pct) * obs_cnt;
    endfunction

    function automatic void rise_settle(input int mag);
        if (share_above()) begin
            if (mag - anchor_mag > NOISE_MARGIN) begin
                cls = CODE_HOT;
                pos_cnt = 0;
            end
        end else if (share_below()) begin
            cls = CODE_IDLE;
        end
    endfunction

    function automatic verdict_t classify_sample(input logic [11:0] adc);
        int level, pol, mag, rate;
        bit f_imp, f_fast, f_amp;
        logic [1:0] alarm;
        verdict_t v;
        level = int'(adc) - QUIESCENT;
        pol = (level > 0) ? 1 : ((level < 0) ? -1 : 0);
        mag = (level < 0) ? -level : level;
        if (mag > 4095) mag = 4095;
        rate = (last_pol * pol <= 0) ? mag : mag - last_mag;
        f_imp  = rate > int'(shadow.impulse_thr);
        f_fast = !f_imp && rate > int'(shadow.fast_thr);
        f_amp  = mag > int'(shadow.amp_thr);
        alarm  = FA_NONE;
        case (cls)
            CODE_OVER: begin
                obs_cnt = bump(obs_cnt);
                if (f_amp) pos_cnt = bump(pos_cnt);
                if (obs_cnt > int'(shadow.min_obs)) begin
                    if (share_above()) begin
                        cls = CODE_HOT;
                        pos_cnt = 0;
                    end else if (share_below()) begin
                        cls = CODE_IDLE;
                    end
                end
            end
            CODE_IMPULSE: begin
                obs_cnt = bump(obs_cnt);
                if (f_amp) begin
                    pos_cnt = bump(pos_cnt);
                    cls = CODE_OVER;
                end else if (f_fast) begin
                    pos_cnt = bump(pos_cnt);
                    cls = CODE_FAST;
                end else if (rate > int'(shadow.slow_thr) &&
                             obs_cnt < int'(shadow.period) / 8) begin
                    pos_cnt = bump(pos_cnt);
                end
                if (obs_cnt >= int'(shadow.min_obs)) rise_settle(mag);
            end
            CODE_FAST: begin
                obs_cnt = bump(obs_cnt);
                if (f_fast) begin
                    pos_cnt = bump(pos_cnt);
                end else if (f_amp) begin
                    pos_cnt = bump(pos_cnt);
                    cls = CODE_OVER;
                end
                if (obs_cnt >= int'(shadow.min_obs)) rise_settle(mag);
            end
            CODE_HOT: begin
                obs_cnt = bump(obs_cnt);
                if (f_amp) begin
                    pos_cnt = bump(pos_cnt);
                    amp_hot_seen = 1'b1;
                end
                if (obs_cnt > int'(shadow.period)) begin
                    if (pos_cnt == 0) begin
                        cls = CODE_IDLE;
                        alarm = amp_hot_seen ? FA_AMP : FA_RATE;
                    end
                    obs_cnt = 0;
                    pos_cnt = 0;
                end
            end
            default: begin
                cls = CODE_IDLE;
                if (f_imp || f_fast || f_amp) begin
                    obs_cnt = 1;
                    pos_cnt = 1;
                    anchor_mag = mag;
                    if (f_amp) cls = CODE_OVER;
                    else if (f_imp) cls = CODE_IMPULSE;
                    else if (f_fast && last_rate >= 0) cls = CODE_FAST;
                end
            end
        endcase
        last_pol  = pol;
        last_mag  = mag;
        last_rate = rate;
        v.fsm_state   = cls;
        v.flags       = {f_amp, f_fast, f_imp};
        v.magnitude   = 12'(mag);
        v.rate        = 13'(rate);
        v.alarm_kind  = alarm;
        return v;
    endfunction

    // Input acceptance, prediction and result checking, all on the rising edge.
    always @(posedge aclk) begin
        verdict_t want, got;
        sample_taken = aresetn && s_tvalid && s_tready;
        if (sample_taken) begin
            expected_verdicts.push_back(classify_sample(s_tdata[11:0]));
            accepted_count++;
        end
        if (aresetn && s_tvalid && !s_tready) input_stalls++;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[2:0], m_tdata[5:3], m_tdata[17:6], m_tdata[30:18], m_tdata[32:31]};
            if (expected_verdicts.size() == 0) begin
                $error("unexpected result beat, data %h", m_tdata);
                mismatches++;
            end else begin
                want = expected_verdicts.pop_front();
                if (got.fsm_state != want.fsm_state) begin
                    $error("fsm_state: expected %0d, got %0d", want.fsm_state, got.fsm_state);
                    mismatches++;
                end
                if (got.flags != want.flags) begin
                    $error("flags: expected %0d, got %0d", want.flags, got.flags);
                    mismatches++;
                end
                if (got.magnitude != want.magnitude) begin
                    $error("magnitude: expected %0d, got %0d", want.magnitude, got.magnitude);
                    mismatches++;
                end
                if (got.rate != want.rate) begin
                    $error("rate: expected %0d, got %0d",
                           $signed(want.rate), $signed(got.rate));
                    mismatches++;
                end
                if (got.alarm_kind != want.alarm_kind) begin
                    $error("alarm_kind: expected %0d, got %0d",
                           want.alarm_kind, got.alarm_kind);
                    mismatches++;
                end
                if (want.fsm_state <= CODE_HOT) states_seen[want.fsm_state] = 1'b1;
                if (want.alarm_kind == FA_AMP) amp_alarms++;
                if (want.alarm_kind == FA_RATE) rate_alarms++;
            end
            checked_count++;
        end
    end

    // Sample driver: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || sample_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_samples.size() == 0) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, pending_samples.pop_front()};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Result receiver: stall pattern redrawn at the end of each random span, plus one
    // long hold-off that backs the pipeline up into the input.
    int rx_mode      = 0;
    int rx_span      = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            m_tready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && checked_count >= 500) begin
            m_tready     <= 1'b0;
            holdoff_left <= 400;
            holdoff_done <= 1'b1;
        end else begin
            if (rx_span == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_span <= $urandom_range(16, 128);
            end else begin
                rx_span <= rx_span - 1;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (rx_span % 4 == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [11:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMPULSE_THR: shadow.impulse_thr = val;
            REG_FAST_THR:    shadow.fast_thr    = val;
            REG_SLOW_THR:    shadow.slow_thr    = val;
            REG_AMP_THR:     shadow.amp_thr     = val;
            REG_MIN_OBS:     shadow.min_obs     = val;
            REG_UPPER_PCT:   shadow.upper_pct   = val[6:0];
            REG_LOWER_PCT:   shadow.lower_pct   = val[6:0];
            default:         shadow.period      = val;
        endcase
        reg_writes++;
    endtask

    task automatic apply_settings(input int imp, input int fast, input int slow, input int amp,
                                  input int min_obs, input int upper, input int lower,
                                  input int period);
        write_reg(REG_IMPULSE_THR, 12'(imp));
        write_reg(REG_FAST_THR, 12'(fast));
        write_reg(REG_SLOW_THR, 12'(slow));
        write_reg(REG_AMP_THR, 12'(amp));
        write_reg(REG_MIN_OBS, 12'(min_obs));
        write_reg(REG_UPPER_PCT, 12'(upper));
        write_reg(REG_LOWER_PCT, 12'(lower));
        write_reg(REG_PERIOD, 12'(period));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_settings(input int period);
        int imp, fast, slow, upper;
        imp   = $urandom_range(150, 2000);
        fast  = $urandom_range(10, imp);
        slow  = $urandom_range(0, fast);
        upper = $urandom_range(0, 100);
        apply_settings(imp, fast, slow, $urandom_range(200, 2000), $urandom_range(0, 24),
                       upper, $urandom_range(0, upper), period);
    endtask

    task automatic wait_all_results();
        while (accepted_count != pushed_count || expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_raw(input logic [11:0] adc);
        pending_samples.push_back(adc);
        pushed_count++;
    endtask

    task automatic push_level(input int lv);
        if (lv > 2047) lv = 2047;
        if (lv < -2048) lv = -2048;
        push_raw(12'(lv + QUIESCENT));
    endtask

    // One stretch of signal: quiet line, fault-like waveforms, raw noise or an edge level.
    task automatic queue_episode();
        int kind, n, amp, half, lv, step, sgn, i;
        kind = $urandom_range(0, 9);
        sgn  = $urandom_range(0, 1) ? 1 : -1;
        amp  = $urandom_range(100, 2047);
        case (kind)
            0, 1: begin
                n = $urandom_range(3, 15);
                for (i = 0; i < n; i++) push_level($urandom_range(0, 24) - 12);
            end
            2, 3: begin
                n    = $urandom_range(10, 60);
                half = $urandom_range(2, 10);
                for (i = 0; i < n; i++) begin
                    lv = ((i % half) + 1) * amp / half;
                    push_level(((i / half) % 2) ? -sgn * lv : sgn * lv);
                end
            end
            4, 5: begin
                n  = $urandom_range(2, 8);
                lv = amp;
                for (i = 0; i < n; i++) begin
                    push_level(sgn * lv);
                    lv = lv / 2;
                end
            end
            6, 7: begin
                n    = $urandom_range(3, 16);
                step = $urandom_range(5, 300);
                lv   = 0;
                for (i = 0; i < n; i++) begin
                    lv += step;
                    push_level(sgn * lv);
                end
            end
            8: begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++) push_raw(12'($urandom_range(0, 4095)));
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       push_raw(12'd0);
                    1:       push_raw(12'd4095);
                    2:       push_raw(12'd2048);
                    3:       push_raw(12'd2047);
                    default: push_raw(12'd2049);
                endcase
            end
        endcase
    endtask

    initial begin
        int phase, base, target, i;
        shadow = '0;
        shadow.period = PERIOD_RESET;
        cls = CODE_IDLE;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Overcurrent into hot, a window with no positives gives a rate false
        // alarm; then a window with an amplitude hit, and a quiet window that
        // ends in an amplitude false alarm. Level extremes close the sequence.
        apply_settings(4095, 4095, 4095, 500, 2, 10, 5, 4);
        for (i = 0; i < 3; i++) push_level(1000);
        for (i = 0; i < 5; i++) push_level(0);
        for (i = 0; i < 4; i++) push_level(1000);
        for (i = 0; i < 9; i++) push_level(0);
        push_raw(12'd2048);
        push_raw(12'd0);
        push_raw(12'd4095);
        push_raw(12'd2049);
        push_raw(12'd2047);
        wait_all_results();

        // An undecided overcurrent stretch that goes hot once the upper
        // percentage is lowered.
        apply_settings(4095, 4095, 0, 100, 100, 100, 0, 1);
        for (i = 0; i < 6; i++) push_level(0);
        for (i = 0; i < 200; i++) push_raw(12'd4095);
        wait_all_results();
        write_reg(REG_UPPER_PCT, 12'd99);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        push_raw(12'd4095);
        wait_all_results();

        base  = pushed_count;
        phase = 0;
        while (pushed_count - base < RANDOM_ITEMS) begin
            case (phase)
                0:       apply_settings(0, 0, 0, 0, 0, 0, 0, 1);
                1:       apply_settings(4095, 4095, 4095, 4095, 4095, 100, 100, 4095);
                2:       pick_settings(0);
                default: pick_settings(($urandom_range(0, 7) == 0) ?
                                       $urandom_range(1, 4095) : $urandom_range(1, 120));
            endcase
            target = pushed_count + $urandom_range(80, 160);
            while (pushed_count < target) queue_episode();
            wait_all_results();
            phase++;
        end

        repeat (8) @(posedge aclk);
        $display("Ran %0d samples over %0d setting phases with %0d register writes;",
                 checked_count, phase + 2, reg_writes);
        $display("states seen %b, false alarms %0d amplitude / %0d rate, %0d input stalls.",
                 states_seen, amp_alarms, rate_alarms, input_stalls);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fsfc_pkg.sv
rtl/fsfc_front.sv
rtl/field_sensor_fault_classifier.sv
rtl/fsfc_checker.sv
test/field_sensor_fault_classifier_tb.sv
